// ===== rtl/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg: types and codes of the priority-selectable FIFO
// Request and response beat layouts, stored entry layout, request and status
// codes, and the sequencer states.
// ----------------------------------------------------------------------------
package psf_pkg;

	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned PRIO_W    = 8;
	localparam int unsigned COUNT_W   = 5;

	localparam logic [1:0] REQ_APPEND    = 2'd0;
	localparam logic [1:0] REQ_POP_HEAD  = 2'd1;
	localparam logic [1:0] REQ_POP_EQUAL = 2'd2;
	localparam logic [1:0] REQ_POP_AT_MOST = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [PAYLOAD_W-1:0] item_payload;
		logic [PRIO_W-1:0]    item_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic                 head_valid;
		logic [PAYLOAD_W-1:0] head_payload;
		logic [PRIO_W-1:0]    head_priority;
		logic [COUNT_W-1:0]   entry_count;
	} rsp_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [PRIO_W-1:0]    prio;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_HEAD,
		S_FILL
	} seq_state_t;

endpackage

// ===== rtl/psf_ram.sv =====
// ----------------------------------------------------------------------------
// psf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psf_ram #(
	parameter int unsigned WIDTH = 40,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/priority_selectable_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// priority_selectable_fifo_unit: ordered queue with priority-matched removal
// Holds up to QUEUE_DEPTH entries in age order in one RAM; removals close the
// gap by moving later entries down one place at a time.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on req/req_valid asks to append an entry at the tail, remove
// the head, remove the oldest entry whose priority equals the key, or remove
// the oldest entry whose priority is at most the key. Each request yields one
// response beat on rsp/rsp_valid with status, the new head and the count.
// req_stall is high while a request is in work; one request is in work at a
// time. Every request ends in S_HEAD, which reads the new head, and S_FILL,
// which loads the response. Remove head first closes up in S_SHIFT; remove
// by key first searches in S_SCAN and, on a match, closes up in S_SHIFT.
// The single RAM read port sets the pace: the key search reads one entry
// per cycle and the close-up moves one entry per cycle.
// The response register holds its beat while rsp_stall is high; the next
// request is still accepted and worked, and waits in its last step until the
// held beat is taken. Reset empties the queue and drops any pending response.
// ----------------------------------------------------------------------------
module priority_selectable_fifo_unit #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  psf_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output psf_pkg::rsp_t   rsp
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	psf_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0]        occ_q, occ_d;
	logic [CW-1:0]        scan_idx_q, scan_idx_d;
	logic                 cmp_vld_q, cmp_vld_d;
	logic [AW-1:0]        cmp_idx_q, cmp_idx_d;
	logic [CW-1:0]        sh_idx_q, sh_idx_d;
	logic                 wpend_q, wpend_d;
	logic [AW-1:0]        wr_idx_q, wr_idx_d;
	logic                 rsp_valid_q;
	logic                 rsp_load;

	logic [1:0]                   status_q, status_d;
	logic                         at_most_q, at_most_d;
	logic [psf_pkg::PRIO_W-1:0]   key_q, key_d;
	psf_pkg::rsp_t                rsp_q;
	psf_pkg::rsp_t                rsp_d;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	psf_pkg::entry_t  ram_wdata;
	logic [AW-1:0]    ram_raddr;
	psf_pkg::entry_t  ram_rdata;

	logic             accept;
	logic             full;
	logic             hit;
	logic [CW-1:0]    sh_idx_m1;

	psf_ram #(
		.WIDTH($bits(psf_pkg::entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_stall = (state_q != psf_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign full      = (occ_q == CW'(QUEUE_DEPTH));
	assign sh_idx_m1 = sh_idx_q - CW'(1);

	// Shared priority comparator
	assign hit = cmp_vld_q && (at_most_q ? (ram_rdata.prio <= key_q)
	                                     : (ram_rdata.prio == key_q));

	always_comb begin
		state_d    = state_q;
		occ_d      = occ_q;
		scan_idx_d = scan_idx_q;
		cmp_vld_d  = 1'b0;
		cmp_idx_d  = cmp_idx_q;
		sh_idx_d   = sh_idx_q;
		wpend_d    = 1'b0;
		wr_idx_d   = wr_idx_q;
		status_d   = status_q;
		at_most_d  = at_most_q;
		key_d      = key_q;
		rsp_load   = 1'b0;
		rsp_d      = rsp_q;
		ram_we     = 1'b0;
		ram_waddr  = wr_idx_q;
		ram_wdata  = ram_rdata;
		ram_raddr  = '0;

		case (state_q)
			psf_pkg::S_IDLE: begin
				if (accept) begin
					key_d     = req.item_priority;
					at_most_d = (req.req_type == psf_pkg::REQ_POP_AT_MOST);
					status_d  = psf_pkg::ST_DONE;
					state_d   = psf_pkg::S_HEAD;
					if (req.req_type == psf_pkg::REQ_APPEND) begin
						if (full) begin
							status_d = psf_pkg::ST_FULL;
						end else begin
							ram_we         = 1'b1;
							ram_waddr      = occ_q[AW-1:0];
							ram_wdata.payload = req.item_payload;
							ram_wdata.prio    = req.item_priority;
							occ_d          = occ_q + CW'(1);
						end
					end else if (occ_q == '0) begin
						status_d = psf_pkg::ST_NONE;
					end else if (req.req_type == psf_pkg::REQ_POP_HEAD) begin
						sh_idx_d = CW'(1);
						state_d  = psf_pkg::S_SHIFT;
					end else begin
						scan_idx_d = '0;
						state_d    = psf_pkg::S_SCAN;
					end
				end
			end
			psf_pkg::S_SCAN: begin
				if (hit) begin
					// drop the read in flight and close up behind the match
					sh_idx_d = CW'(cmp_idx_q) + CW'(1);
					state_d  = psf_pkg::S_SHIFT;
				end else if (scan_idx_q >= occ_q) begin
					status_d = psf_pkg::ST_NONE;
					state_d  = psf_pkg::S_HEAD;
				end else begin
					ram_raddr  = scan_idx_q[AW-1:0];
					cmp_vld_d  = 1'b1;
					cmp_idx_d  = scan_idx_q[AW-1:0];
					scan_idx_d = scan_idx_q + CW'(1);
				end
			end
			psf_pkg::S_SHIFT: begin
				// write back the entry read last cycle one place lower
				if (wpend_q) begin
					ram_we    = 1'b1;
					ram_waddr = wr_idx_q;
					ram_wdata = ram_rdata;
				end
				if (sh_idx_q < occ_q) begin
					ram_raddr = sh_idx_q[AW-1:0];
					wpend_d   = 1'b1;
					wr_idx_d  = sh_idx_m1[AW-1:0];
					sh_idx_d  = sh_idx_q + CW'(1);
				end else begin
					occ_d   = occ_q - CW'(1);
					state_d = psf_pkg::S_HEAD;
				end
			end
			psf_pkg::S_HEAD: begin
				ram_raddr = '0;
				state_d   = psf_pkg::S_FILL;
			end
			psf_pkg::S_FILL: begin
				ram_raddr           = '0;
				rsp_d.status        = status_q;
				rsp_d.head_valid    = (occ_q != '0);
				rsp_d.head_payload  = (occ_q != '0) ? ram_rdata.payload : '0;
				rsp_d.head_priority = (occ_q != '0) ? ram_rdata.prio : '0;
				rsp_d.entry_count   = psf_pkg::COUNT_W'(occ_q);
				// hold here until the previous response is taken
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = psf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = psf_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psf_pkg::S_IDLE;
			occ_q       <= '0;
			cmp_vld_q   <= 1'b0;
			wpend_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			occ_q     <= occ_d;
			cmp_vld_q <= cmp_vld_d;
			wpend_q   <= wpend_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_q <= scan_idx_d;
		cmp_idx_q  <= cmp_idx_d;
		sh_idx_q   <= sh_idx_d;
		wr_idx_q   <= wr_idx_d;
		status_q   <= status_d;
		at_most_q  <= at_most_d;
		key_q      <= key_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The count never exceeds the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	// The count moves by at most one per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + CW'(1)) ||
		(occ_q + CW'(1) == $past(occ_q)))
		else $error("occupancy jumped by more than one");

	// Close-up writes stay inside the held entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psf_pkg::S_SHIFT && wpend_q) |-> (CW'(wr_idx_q) + CW'(1) < occ_q))
		else $error("close-up write beyond tail");

	// A full status is reported only with a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && status_q == psf_pkg::ST_FULL) |-> full)
		else $error("full status on a queue with room");

endmodule

// ===== dv/psf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psf_checker: response predictor and scoreboard for the priority FIFO
// Watches the request and response channels, keeps its own copy of the
// queue, predicts one response per accepted request and compares each
// accepted response beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module psf_checker #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  psf_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  psf_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending_count
);

	import psf_pkg::*;

	logic [PAYLOAD_W-1:0] held_payload [QUEUE_DEPTH];
	logic [PRIO_W-1:0]    held_prio [QUEUE_DEPTH];
	int unsigned          held_count = 0;
	rsp_t                 expected_rsp_q [$];
	rsp_t                 oldest_rsp;
	int                   mismatches = 0;

	// Apply one request to the shadow queue and return the response it causes.
	function automatic rsp_t apply_request(input req_t r);
		int unsigned pos;
		int unsigned i;
		rsp_t        e;
		e = '0;
		e.status = ST_DONE;
		pos = held_count;
		case (r.req_type)
		REQ_APPEND: begin
			if (held_count >= QUEUE_DEPTH) begin
				e.status = ST_FULL;
			end else begin
				held_payload[held_count] = r.item_payload;
				held_prio[held_count] = r.item_priority;
				held_count++;
			end
		end
		REQ_POP_HEAD: begin
			if (held_count == 0)
				e.status = ST_NONE;
			else
				pos = 0;
		end
		default: begin
			// take the oldest matching entry only
			for (i = 0; i < held_count; i++) begin
				if (pos == held_count) begin
					if (r.req_type == REQ_POP_AT_MOST ? held_prio[i] <= r.item_priority
						: held_prio[i] == r.item_priority)
						pos = i;
				end
			end
			if (pos == held_count)
				e.status = ST_NONE;
		end
		endcase
		if (r.req_type != REQ_APPEND && pos < held_count) begin
			// close the gap, keeping age order
			for (i = pos; i + 1 < held_count; i++) begin
				held_payload[i] = held_payload[i + 1];
				held_prio[i] = held_prio[i + 1];
			end
			held_count--;
		end
		if (held_count > 0) begin
			e.head_valid = 1'b1;
			e.head_payload = held_payload[0];
			e.head_priority = held_prio[0];
		end
		e.entry_count = COUNT_W'(held_count);
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			expected_rsp_q.delete();
			fail_count <= mismatches;
			pending_count <= 0;
		end else begin
			// retire the response beat first, then queue the new prediction
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response beat with none expected: %p", $time, rsp);
				end else begin
					oldest_rsp = expected_rsp_q.pop_front();
					if (rsp.status !== oldest_rsp.status
						|| rsp.head_valid !== oldest_rsp.head_valid
						|| rsp.head_payload !== oldest_rsp.head_payload
						|| rsp.head_priority !== oldest_rsp.head_priority
						|| rsp.entry_count !== oldest_rsp.entry_count) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch: expected status %0d head %0d %h/%0d count %0d",
								$time, oldest_rsp.status, oldest_rsp.head_valid,
								oldest_rsp.head_payload, oldest_rsp.head_priority,
								oldest_rsp.entry_count);
							$display("%0t: mismatch: actual status %0d head %0d %h/%0d count %0d",
								$time, rsp.status, rsp.head_valid,
								rsp.head_payload, rsp.head_priority, rsp.entry_count);
						end
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsp_q.push_back(apply_request(req));
			fail_count <= mismatches;
			pending_count <= expected_rsp_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for priority_selectable_fifo_unit
// Drives directed requests (empty queue, fill to full, every removal kind,
// match and no match) and then random request mixes that swing the queue
// between empty and full, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;

	import psf_pkg::*;

	localparam int unsigned DEPTH      = 16;
	localparam int unsigned RAND_ITEMS = 1125;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY
	} stall_mode_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int          fail_count;
	int          pending_count;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;

	priority_selectable_fifo_unit #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	psf_checker #(
		.QUEUE_DEPTH(DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic req_t make_req(input logic [1:0] kind, input logic [31:0] pay,
		input logic [7:0] prio);
		req_t r;
		r.req_type = kind;
		r.item_payload = pay;
		r.item_priority = prio;
		return r;
	endfunction

	// Offer one beat and hold it until accepted; idle between bursts.
	task automatic send_beat(input req_t r);
		int unsigned gap;
		@(negedge clk);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 40)
				: $urandom_range(12, 0);
			gap = $urandom_range(12, 1);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// receiver stall pattern, with one long hold-off to back the block up
	initial begin
		stall_mode_t mode;
		int unsigned span;
		bit          long_hold_done;
		rsp_stall = 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!long_hold_done && items_sent >= 500) begin
				long_hold_done = 1'b1;
				repeat (400) begin
					@(negedge clk);
					rsp_stall <= 1'b1;
				end
			end else begin
				mode = stall_mode_t'($urandom_range(2, 0));
				span = $urandom_range(160, 16);
				repeat (span) begin
					@(negedge clk);
					case (mode)
					STALL_NONE:  rsp_stall <= 1'b0;
					STALL_LIGHT: rsp_stall <= ($urandom_range(3, 0) == 0);
					default:     rsp_stall <= ($urandom_range(9, 0) < 7);
					endcase
				end
			end
		end
	end

	initial begin
		int unsigned i;
		int unsigned append_pct;
		int unsigned prio_base;
		req_t        r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// removals on an empty queue
		send_beat(make_req(REQ_POP_HEAD, $urandom, 8'($urandom)));
		send_beat(make_req(REQ_POP_EQUAL, $urandom, 8'd0));
		send_beat(make_req(REQ_POP_AT_MOST, $urandom, 8'd255));
		// fill to capacity, payload and priority extremes at the head
		for (i = 0; i < DEPTH; i++)
			send_beat(make_req(REQ_APPEND,
				(i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom,
				(i == 0) ? 8'd255 : 8'(i * 16 + 3)));
		send_beat(make_req(REQ_APPEND, $urandom, 8'($urandom)));
		send_beat(make_req(REQ_POP_EQUAL, $urandom, 8'd100));
		send_beat(make_req(REQ_POP_EQUAL, $urandom, 8'd83));
		send_beat(make_req(REQ_POP_AT_MOST, $urandom, 8'd0));
		send_beat(make_req(REQ_POP_AT_MOST, $urandom, 8'd50));
		send_beat(make_req(REQ_POP_HEAD, $urandom, 8'($urandom)));

		append_pct = 50;
		prio_base = 0;
		for (i = 0; i < RAND_ITEMS; i++) begin
			// swing between filling and draining phases
			if (i % 48 == 0) begin
				case ($urandom_range(2, 0))
				0:       append_pct = 75;
				1:       append_pct = 50;
				default: append_pct = 25;
				endcase
				prio_base = $urandom_range(248, 0);
			end
			if (i == 700) begin
				// drain everything before going on
				@(negedge clk);
				req_valid <= 1'b0;
				while (pending_count != 0)
					@(posedge clk);
			end
			r.req_type = ($urandom_range(99, 0) < append_pct) ? REQ_APPEND
				: 2'($urandom_range(3, 1));
			r.item_payload = $urandom;
			// draw keys from a narrow pool so equal matches are common
			r.item_priority = ($urandom_range(9, 0) < 6) ? 8'(prio_base + $urandom_range(7, 0))
				: 8'($urandom);
			send_beat(r);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (64)
			@(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/psf_pkg.sv
rtl/psf_ram.sv
rtl/priority_selectable_fifo_unit.sv
dv/psf_checker.sv
dv/tb_top.sv
